[rtl/core/qte_pkg.sv]
package qte_pkg;

  localparam int QuatWidthDef    = 16;
  localparam int AngleWidthDef   = 16;
  localparam int CordicStagesDef = 16;

  localparam logic [31:0] TurnPi     = 32'h8000_0000;
  localparam logic [31:0] TurnHalfPi = 32'h4000_0000;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [31:0] AtanTurns [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  typedef struct packed {
    logic        hold;
    logic [31:0] acc;
  } cordic_ctl_t;

endpackage

[rtl/core/qte_sqrt_cell.sv]
module qte_sqrt_cell #(
  parameter int BitPos = 62
) (
  input  logic        clk_i,
  input  logic        ce_i,
  input  logic [63:0] v_i,
  input  logic [63:0] res_i,
  output logic [63:0] v_o,
  output logic [63:0] res_o
);
  localparam logic [63:0] Bit = 64'd1 << BitPos;

  logic [63:0] trial;
  logic [63:0] v_d, res_d, v_q, res_q;

  assign trial = res_i + Bit;

  always_comb begin
    if (v_i >= trial) begin
      v_d   = v_i - trial;
      res_d = (res_i >> 1) + Bit;
    end else begin
      v_d   = v_i;
      res_d = res_i >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      v_q   <= v_d;
      res_q <= res_d;
    end
  end

  assign v_o   = v_q;
  assign res_o = res_q;
endmodule

[rtl/core/qte_cordic_cell.sv]
module qte_cordic_cell #(
  parameter int DW    = 35,
  parameter int Stage = 0
) (
  input  logic                clk_i,
  input  logic                ce_i,
  input  logic signed [DW-1:0] x_i,
  input  logic signed [DW-1:0] y_i,
  input  qte_pkg::cordic_ctl_t ctl_i,
  output logic signed [DW-1:0] x_o,
  output logic signed [DW-1:0] y_o,
  output qte_pkg::cordic_ctl_t ctl_o
);
  import qte_pkg::*;

  logic signed [DW-1:0] xs, ys, x_d, y_d, x_q, y_q;
  cordic_ctl_t ctl_d, ctl_q;

  assign xs = x_i >>> Stage;
  assign ys = y_i >>> Stage;

  always_comb begin
    x_d   = x_i;
    y_d   = y_i;
    ctl_d = ctl_i;
    if (!ctl_i.hold && y_i > 0) begin
      x_d       = x_i + ys;
      y_d       = y_i - xs;
      ctl_d.acc = ctl_i.acc + AtanTurns[Stage];
    end else if (!ctl_i.hold && y_i < 0) begin
      x_d       = x_i - ys;
      y_d       = y_i + xs;
      ctl_d.acc = ctl_i.acc - AtanTurns[Stage];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      x_q   <= x_d;
      y_q   <= y_d;
      ctl_q <= ctl_d;
    end
  end

  assign x_o   = x_q;
  assign y_o   = y_q;
  assign ctl_o = ctl_q;
endmodule

[rtl/core/qte_atan2.sv]
module qte_atan2 #(
  parameter int IW     = 35,
  parameter int DW     = 37,
  parameter int Stages = 16
) (
  input  logic                clk_i,
  input  logic                ce_i,
  input  logic signed [IW-1:0] y_i,
  input  logic signed [IW-1:0] x_i,
  output logic [31:0]          turn_o
);
  import qte_pkg::*;

  logic signed [DW-1:0] xe, ye, x_d, y_d;
  cordic_ctl_t ctl_d;
  logic signed [DW-1:0] cx [Stages+1];
  logic signed [DW-1:0] cy [Stages+1];
  cordic_ctl_t cc [Stages+1];

  assign xe = DW'(x_i);
  assign ye = DW'(y_i);

  always_comb begin
    x_d       = xe;
    y_d       = ye;
    ctl_d     = '0;
    if (y_i == 0) begin
      ctl_d.hold = 1'b1;
      ctl_d.acc  = (x_i < 0) ? TurnPi : 32'd0;
    end else if (x_i == 0) begin
      ctl_d.hold = 1'b1;
      ctl_d.acc  = (y_i > 0) ? TurnHalfPi : (32'd0 - TurnHalfPi);
    end else if (x_i < 0) begin
      x_d       = -xe;
      y_d       = -ye;
      ctl_d.acc = TurnPi;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      cx[0] <= x_d;
      cy[0] <= y_d;
      cc[0] <= ctl_d;
    end
  end

  for (genvar i = 0; i < Stages; i++) begin : g_cell
    qte_cordic_cell #(.DW(DW), .Stage(i)) u_cell (
      .clk_i (clk_i),
      .ce_i  (ce_i),
      .x_i   (cx[i]),
      .y_i   (cy[i]),
      .ctl_i (cc[i]),
      .x_o   (cx[i+1]),
      .y_o   (cy[i+1]),
      .ctl_o (cc[i+1])
    );
  end

  assign turn_o = cc[Stages].acc;
endmodule

[rtl/core/quaternion_to_euler_angles_unit.sv]
// Quaternion to ZYX Euler angles, fully pipelined.
// Pipeline stages: products, sums, 32 square-root cells, one CORDIC prestage,
// CORDIC_STAGES cells, output stage.
// Throughput: one transaction per cycle; the whole pipeline stalls only while
// a finished result is not taken. Reset clears the valid bits only.
module quaternion_to_euler_angles_unit #(
  parameter int QUAT_WIDTH    = qte_pkg::QuatWidthDef,
  parameter int ANGLE_WIDTH   = qte_pkg::AngleWidthDef,
  parameter int CORDIC_STAGES = qte_pkg::CordicStagesDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // quat_x, quat_y, quat_z, quat_w, zero pad
  input  logic [((4*QUAT_WIDTH+7)/8)*8-1:0] s_axis_tdata_i,
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  // roll_angle, pitch_angle, yaw_angle, zero pad
  output logic [((3*ANGLE_WIDTH+7)/8)*8-1:0] m_axis_tdata_o,
  // pitch_clamped
  output logic m_axis_tuser_o
);
  localparam int QW        = QUAT_WIDTH;
  localparam int AW        = ANGLE_WIDTH;
  localparam int OutW      = ((3*AW+7)/8)*8;
  localparam int ProdShift = (QW > 28) ? 2*(QW-28) : 0;
  localparam int PW        = 2*QW - ProdShift;
  localparam int SW        = PW + 3;
  localparam int OneBits   = 2*(QW-2) - ProdShift;
  localparam int SqrtPre   = 61 - OneBits;
  localparam int NStg      = CORDIC_STAGES + 36;
  localparam int AngDly    = 32;
  localparam int ClmpDly   = CORDIC_STAGES + 34;
  localparam int RndSh     = (AW < 32) ? 31-AW : 0;
  localparam int DropSh    = 32 - AW;
  localparam logic signed [SW-1:0] One = SW'(1) <<< OneBits;

  function automatic logic [AW-1:0] to_angle(input logic [31:0] t);
    logic [32:0] r;
    r = {1'b0, t} + ((AW < 32) ? (33'd1 << RndSh) : 33'd0);
    r = r >> DropSh;
    return r[AW-1:0];
  endfunction

  logic ce;
  logic [NStg-1:0] vld_q;

  assign ce              = !vld_q[NStg-1] || m_axis_tready_i;
  assign s_axis_tready_o = ce;
  assign m_axis_tvalid_o = vld_q[NStg-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ce) begin
      vld_q <= {vld_q[NStg-2:0], s_axis_tvalid_i};
    end
  end

  // products
  logic signed [QW-1:0] qx, qy, qz, qw;
  logic signed [2*QW-1:0] m_wx, m_yz, m_xx, m_yy, m_wz, m_xy, m_zz, m_wy, m_zx;
  logic signed [PW-1:0] p_wx_q, p_yz_q, p_xx_q, p_yy_q, p_wz_q, p_xy_q, p_zz_q;
  logic signed [PW-1:0] p_wy_q, p_zx_q;

  assign qx = s_axis_tdata_i[QW-1:0];
  assign qy = s_axis_tdata_i[2*QW-1:QW];
  assign qz = s_axis_tdata_i[3*QW-1:2*QW];
  assign qw = s_axis_tdata_i[4*QW-1:3*QW];

  assign m_wx = qw * qx;
  assign m_yz = qy * qz;
  assign m_xx = qx * qx;
  assign m_yy = qy * qy;
  assign m_wz = qw * qz;
  assign m_xy = qx * qy;
  assign m_zz = qz * qz;
  assign m_wy = qw * qy;
  assign m_zx = qz * qx;

  always_ff @(posedge clk_i) begin
    if (ce) begin
      p_wx_q <= PW'(m_wx >>> ProdShift);
      p_yz_q <= PW'(m_yz >>> ProdShift);
      p_xx_q <= PW'(m_xx >>> ProdShift);
      p_yy_q <= PW'(m_yy >>> ProdShift);
      p_wz_q <= PW'(m_wz >>> ProdShift);
      p_xy_q <= PW'(m_xy >>> ProdShift);
      p_zz_q <= PW'(m_zz >>> ProdShift);
      p_wy_q <= PW'(m_wy >>> ProdShift);
      p_zx_q <= PW'(m_zx >>> ProdShift);
    end
  end

  // sums and pitch sine clamp
  logic signed [SW-1:0] sr_d, cr_d, sy_d, cy_d, sp_raw, sp_c;
  logic signed [SW-1:0] sr_q, cr_q, sy_q, cy_q, sp_hi, sp_lo;
  logic clamp_d;
  logic [63:0] va_q, vb_q;

  assign sr_d   = (SW'(p_wx_q) + SW'(p_yz_q)) <<< 1;
  assign cr_d   = One - ((SW'(p_xx_q) + SW'(p_yy_q)) <<< 1);
  assign sy_d   = (SW'(p_wz_q) + SW'(p_xy_q)) <<< 1;
  assign cy_d   = One - ((SW'(p_yy_q) + SW'(p_zz_q)) <<< 1);
  assign sp_raw = (SW'(p_wy_q) - SW'(p_zx_q)) <<< 1;

  always_comb begin
    sp_c    = sp_raw;
    clamp_d = 1'b0;
    if (sp_raw > One) begin
      sp_c    = One;
      clamp_d = 1'b1;
    end else if (sp_raw < -One) begin
      sp_c    = -One;
      clamp_d = 1'b1;
    end
  end

  assign sp_hi = One + sp_c;
  assign sp_lo = One - sp_c;

  always_ff @(posedge clk_i) begin
    if (ce) begin
      sr_q <= sr_d;
      cr_q <= cr_d;
      sy_q <= sy_d;
      cy_q <= cy_d;
      va_q <= 64'(unsigned'(sp_hi)) << SqrtPre;
      vb_q <= 64'(unsigned'(sp_lo)) << SqrtPre;
    end
  end

  // roll and yaw
  logic [31:0] roll_turn, yaw_turn;
  logic [31:0] roll_dly_q [AngDly];
  logic [31:0] yaw_dly_q [AngDly];
  logic [ClmpDly-1:0] clamp_dly_q;

  qte_atan2 #(.IW(SW), .DW(SW+2), .Stages(CORDIC_STAGES)) u_roll (
    .clk_i  (clk_i),
    .ce_i   (ce),
    .y_i    (sr_q),
    .x_i    (cr_q),
    .turn_o (roll_turn)
  );

  qte_atan2 #(.IW(SW), .DW(SW+2), .Stages(CORDIC_STAGES)) u_yaw (
    .clk_i  (clk_i),
    .ce_i   (ce),
    .y_i    (sy_q),
    .x_i    (cy_q),
    .turn_o (yaw_turn)
  );

  always_ff @(posedge clk_i) begin
    if (ce) begin
      roll_dly_q[0] <= roll_turn;
      yaw_dly_q[0]  <= yaw_turn;
      for (int k = 1; k < AngDly; k++) begin
        roll_dly_q[k] <= roll_dly_q[k-1];
        yaw_dly_q[k]  <= yaw_dly_q[k-1];
      end
      clamp_dly_q <= {clamp_dly_q[ClmpDly-2:0], clamp_d};
    end
  end

  // pitch: square roots then half-angle atan2
  logic [63:0] sa_v [33];
  logic [63:0] sa_r [33];
  logic [63:0] sb_v [33];
  logic [63:0] sb_r [33];

  assign sa_v[0] = va_q;
  assign sa_r[0] = '0;
  assign sb_v[0] = vb_q;
  assign sb_r[0] = '0;

  for (genvar k = 0; k < 32; k++) begin : g_sqrt
    qte_sqrt_cell #(.BitPos(62-2*k)) u_sqa (
      .clk_i (clk_i),
      .ce_i  (ce),
      .v_i   (sa_v[k]),
      .res_i (sa_r[k]),
      .v_o   (sa_v[k+1]),
      .res_o (sa_r[k+1])
    );
    qte_sqrt_cell #(.BitPos(62-2*k)) u_sqb (
      .clk_i (clk_i),
      .ce_i  (ce),
      .v_i   (sb_v[k]),
      .res_i (sb_r[k]),
      .v_o   (sb_v[k+1]),
      .res_o (sb_r[k+1])
    );
  end

  logic [31:0] half_turn;

  qte_atan2 #(.IW(33), .DW(35), .Stages(CORDIC_STAGES)) u_pitch (
    .clk_i  (clk_i),
    .ce_i   (ce),
    .y_i    (signed'({1'b0, sa_r[32][31:0]})),
    .x_i    (signed'({1'b0, sb_r[32][31:0]})),
    .turn_o (half_turn)
  );

  // output stage
  logic signed [33:0] pt_raw, pt_c;
  logic [AW-1:0] roll_q, pitch_q, yaw_q;
  logic clamp_q;

  assign pt_raw = (34'(signed'(half_turn)) <<< 1) - 34'sd1073741824;

  always_comb begin
    pt_c = pt_raw;
    if (pt_raw > 34'sd1073741824) begin
      pt_c = 34'sd1073741824;
    end else if (pt_raw < -34'sd1073741824) begin
      pt_c = -34'sd1073741824;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      roll_q  <= to_angle(roll_dly_q[AngDly-1]);
      yaw_q   <= to_angle(yaw_dly_q[AngDly-1]);
      pitch_q <= to_angle(pt_c[31:0]);
      clamp_q <= clamp_dly_q[ClmpDly-1];
    end
  end

  assign m_axis_tdata_o = OutW'({yaw_q, pitch_q, roll_q});
  assign m_axis_tuser_o = clamp_q;
endmodule
